// ===== rtl/rbl_pkg.sv =====
package rbl_pkg;

    localparam int MAX_LINES = 64;
    localparam int COORD_W   = 16;
    localparam int STRIDE_W  = 16;
    localparam int PBITS_W   = 7;
    localparam int STEP_W    = STRIDE_W + 3;
    localparam int ADDR_W    = 36;
    localparam int LEN_W     = 23;
    localparam int WIDTH_W   = COORD_W + 1;
    localparam int VPROD_W   = COORD_W + STEP_W;
    localparam int HPROD_W   = COORD_W + PBITS_W;
    localparam int ROWS_W    = $clog2(MAX_LINES + 1);
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 96;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ROW   = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_TALL  = 2'd2
    } rbl_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_CHECK,
        ST_MULT,
        ST_SUM,
        ST_ROWS,
        ST_STATUS
    } rbl_state_t;

    typedef struct packed {
        logic load_in;
        logic calc_bounds;
        logic calc_check;
        logic calc_mult;
        logic calc_sum;
        logic row_step;
        logic sel_status;
    } rbl_cmd_t;

    typedef struct packed {
        logic empty;
        logic too_tall;
        logic last_row;
    } rbl_stat_t;

endpackage

// ===== rtl/rbl_datapath.sv =====
module rbl_datapath import rbl_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rbl_cmd_t                   cmd,
    output rbl_stat_t                  stat,
    input  logic signed [COORD_W-1:0]  dst_left,
    input  logic signed [COORD_W-1:0]  dst_top,
    input  logic signed [COORD_W-1:0]  dst_right,
    input  logic signed [COORD_W-1:0]  dst_bottom,
    input  logic        [STRIDE_W-1:0] dst_stride,
    input  logic signed [COORD_W-1:0]  src_left,
    input  logic signed [COORD_W-1:0]  src_top,
    input  logic signed [COORD_W-1:0]  src_right,
    input  logic signed [COORD_W-1:0]  src_bottom,
    input  logic        [STRIDE_W-1:0] src_stride,
    input  logic        [PBITS_W-1:0]  pixel_bits,
    output logic        [ADDR_W-1:0]   dst_bit_addr,
    output logic        [ADDR_W-1:0]   src_bit_addr,
    output logic        [LEN_W-1:0]    length_bits,
    output rbl_status_t                status,
    output logic                       last
);

    logic signed [COORD_W-1:0] dst_left_reg, dst_top_reg, dst_right_reg, dst_bottom_reg;
    logic signed [COORD_W-1:0] src_left_reg, src_top_reg, src_right_reg, src_bottom_reg;
    logic        [PBITS_W-1:0] bpp_reg;
    logic        [STEP_W-1:0]  dst_step_reg, src_step_reg;

    logic signed [COORD_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg;

    logic                      empty_reg, too_tall_reg;
    logic        [ROWS_W-1:0]  rows_left_reg;
    logic        [WIDTH_W-1:0] width_reg;
    logic        [COORD_W-1:0] dst_dy_reg, dst_dx_reg, src_dy_reg, src_dx_reg;

    logic        [VPROD_W-1:0] dst_vprod_reg, src_vprod_reg;
    logic        [HPROD_W-1:0] dst_hprod_reg, src_hprod_reg;
    logic        [LEN_W-1:0]   length_reg;

    logic        [ADDR_W-1:0]  dst_row_addr_reg, src_row_addr_reg;

    logic signed [COORD_W:0]   xdiff, ydiff;
    logic        [COORD_W-1:0] dst_dy_next, dst_dx_next, src_dy_next, src_dx_next;
    logic                      empty_next, too_tall_next;

    always_comb begin
        xdiff = $signed({x1_reg[COORD_W-1], x1_reg}) - $signed({x0_reg[COORD_W-1], x0_reg});
        ydiff = $signed({y1_reg[COORD_W-1], y1_reg}) - $signed({y0_reg[COORD_W-1], y0_reg});
        empty_next = (x0_reg > x1_reg) || (y0_reg > y1_reg);
        too_tall_next = !empty_next && (ydiff >= $signed((COORD_W + 1)'(MAX_LINES)));
        dst_dy_next = COORD_W'(y0_reg - dst_top_reg);
        dst_dx_next = COORD_W'(x0_reg - dst_left_reg);
        src_dy_next = COORD_W'(y0_reg - src_top_reg);
        src_dx_next = COORD_W'(x0_reg - src_left_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            dst_left_reg   <= dst_left;
            dst_top_reg    <= dst_top;
            dst_right_reg  <= dst_right;
            dst_bottom_reg <= dst_bottom;
            src_left_reg   <= src_left;
            src_top_reg    <= src_top;
            src_right_reg  <= src_right;
            src_bottom_reg <= src_bottom;
            dst_step_reg   <= {dst_stride, 3'b000};
            src_step_reg   <= {src_stride, 3'b000};
            bpp_reg        <= (pixel_bits < PBITS_W'(8)) ? pixel_bits
                                                         : (pixel_bits & PBITS_W'(8'h78));
        end
        if (cmd.calc_bounds) begin
            x0_reg <= (dst_left_reg > src_left_reg) ? dst_left_reg : src_left_reg;
            x1_reg <= (dst_right_reg < src_right_reg) ? dst_right_reg : src_right_reg;
            y0_reg <= (dst_top_reg > src_top_reg) ? dst_top_reg : src_top_reg;
            y1_reg <= (dst_bottom_reg < src_bottom_reg) ? dst_bottom_reg : src_bottom_reg;
        end
        if (cmd.calc_check) begin
            width_reg  <= {1'b0, xdiff[COORD_W-1:0]} + WIDTH_W'(1);
            dst_dy_reg <= dst_dy_next;
            dst_dx_reg <= dst_dx_next;
            src_dy_reg <= src_dy_next;
            src_dx_reg <= src_dx_next;
        end
        if (cmd.calc_mult) begin
            dst_vprod_reg <= VPROD_W'(dst_dy_reg) * VPROD_W'(dst_step_reg);
            src_vprod_reg <= VPROD_W'(src_dy_reg) * VPROD_W'(src_step_reg);
            dst_hprod_reg <= HPROD_W'(dst_dx_reg) * HPROD_W'(bpp_reg);
            src_hprod_reg <= HPROD_W'(src_dx_reg) * HPROD_W'(bpp_reg);
            length_reg    <= LEN_W'(width_reg) * LEN_W'(bpp_reg);
        end
        if (cmd.calc_sum) begin
            dst_row_addr_reg <= ADDR_W'(dst_vprod_reg) + ADDR_W'(dst_hprod_reg);
            src_row_addr_reg <= ADDR_W'(src_vprod_reg) + ADDR_W'(src_hprod_reg);
        end else if (cmd.row_step) begin
            dst_row_addr_reg <= dst_row_addr_reg + ADDR_W'(dst_step_reg);
            src_row_addr_reg <= src_row_addr_reg + ADDR_W'(src_step_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_reg     <= 1'b0;
            too_tall_reg  <= 1'b0;
            rows_left_reg <= '0;
        end else if (cmd.calc_check) begin
            empty_reg     <= empty_next;
            too_tall_reg  <= too_tall_next;
            rows_left_reg <= ydiff[ROWS_W-1:0] + ROWS_W'(1);
        end else if (cmd.row_step) begin
            rows_left_reg <= rows_left_reg - ROWS_W'(1);
        end
    end

    always_comb begin
        stat.empty    = empty_reg;
        stat.too_tall = too_tall_reg;
        stat.last_row = (rows_left_reg == ROWS_W'(1));
        if (cmd.sel_status) begin
            dst_bit_addr = '0;
            src_bit_addr = '0;
            length_bits  = '0;
            status       = empty_reg ? STATUS_EMPTY : STATUS_TALL;
            last         = 1'b1;
        end else begin
            dst_bit_addr = dst_row_addr_reg;
            src_bit_addr = src_row_addr_reg;
            length_bits  = length_reg;
            status       = STATUS_ROW;
            last         = stat.last_row;
        end
    end

    a_rows_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_step |=> rows_left_reg == $past(rows_left_reg) - ROWS_W'(1))
        else $error("row count did not step down by one");

    a_addr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_step |=> dst_row_addr_reg == $past(dst_row_addr_reg + ADDR_W'(dst_step_reg)))
        else $error("destination row address did not advance by the stride");

    a_no_step_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_step |-> !stat.last_row && rows_left_reg != '0)
        else $error("row step taken past the final row");

    a_tall_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        too_tall_reg |-> !empty_reg)
        else $error("overlap flagged both empty and too tall");

endmodule

// ===== rtl/rbl_ctrl.sv =====
module rbl_ctrl import rbl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  rbl_stat_t stat,
    output rbl_cmd_t  cmd
);

    rbl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_BOUNDS;
                end
            end
            ST_BOUNDS: begin
                cmd.calc_bounds = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.calc_check = 1'b1;
                state_next     = ST_MULT;
            end
            ST_MULT: begin
                cmd.calc_mult = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                if (stat.empty || stat.too_tall) begin
                    state_next = ST_STATUS;
                end else begin
                    cmd.calc_sum = 1'b1;
                    state_next   = ST_ROWS;
                end
            end
            ST_ROWS: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (stat.last_row) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.row_step = 1'b1;
                    end
                end
            end
            ST_STATUS: begin
                m_tvalid       = 1'b1;
                cmd.sel_status = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROWS && m_tready && stat.last_row |=> state_reg == ST_IDLE)
        else $error("final row taken but controller did not return to idle");

    a_status_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STATUS && m_tready |=> state_reg == ST_IDLE)
        else $error("status transaction not followed by idle");

endmodule

// ===== rtl/rect_blit_line_address_generator_core.sv =====
// Channel  Direction  Ports                                       Content
// s_       in         s_tvalid, s_tready, s_tdata[167:0]          one blit request
// m_       out        m_tvalid, m_tready, m_tdata[95:0], m_tuser,  one line copy command
//                     m_tlast                                     or one status result
//
// A request is accepted in the idle state and then passes through the setup before its first result.
// Rows then leave at one per cycle while m_tready holds high; a request of H rows (H up to 64)
// gives H line commands, and an empty or too tall overlap gives one status result.
// The setup runs through a bounds (intersect), a check, a multiply and an add register stage.
// Reset is synchronous and active low; it returns the controller to idle.
// A stall on m_ holds the current result and no new request is taken until the last one leaves.
module rect_blit_line_address_generator_core import rbl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // dst_left, dst_top, dst_right, dst_bottom, dst_stride, src_left, src_top,
    // src_right, src_bottom, src_stride, pixel_bits, zero fill.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // dst_bit_addr, src_bit_addr, length_bits, zero fill.
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status.
    output logic [STATUS_W-1:0]   m_tuser,
    output logic                  m_tlast
);

    rbl_cmd_t    cmd;
    rbl_stat_t   stat;
    logic [ADDR_W-1:0] dst_bit_addr, src_bit_addr;
    logic [LEN_W-1:0]  length_bits;
    rbl_status_t status;

    rbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbl_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .dst_left     ($signed(s_tdata[15:0])),
        .dst_top      ($signed(s_tdata[31:16])),
        .dst_right    ($signed(s_tdata[47:32])),
        .dst_bottom   ($signed(s_tdata[63:48])),
        .dst_stride   (s_tdata[79:64]),
        .src_left     ($signed(s_tdata[95:80])),
        .src_top      ($signed(s_tdata[111:96])),
        .src_right    ($signed(s_tdata[127:112])),
        .src_bottom   ($signed(s_tdata[143:128])),
        .src_stride   (s_tdata[159:144]),
        .pixel_bits   (s_tdata[166:160]),
        .dst_bit_addr (dst_bit_addr),
        .src_bit_addr (src_bit_addr),
        .length_bits  (length_bits),
        .status       (status),
        .last         (m_tlast)
    );

    assign m_tdata = {1'b0, length_bits, src_bit_addr, dst_bit_addr};
    assign m_tuser = status;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rbl_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BLITS = 300;

    typedef struct {
        shortint dl, dt, dr, db;
        logic [STRIDE_W-1:0] ds;
        shortint sl, st, sr, sb;
        logic [STRIDE_W-1:0] ss;
        logic [PBITS_W-1:0] pb;
    } blit_req_t;

    typedef struct {
        logic [ADDR_W-1:0] dst_addr;
        logic [ADDR_W-1:0] src_addr;
        logic [LEN_W-1:0] len;
        rbl_status_t status;
        logic last;
    } line_cmd_t;

    typedef struct {
        blit_req_t req;
        bit fixed;
        line_cmd_t cmd;
    } blit_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic m_tlast;

    line_cmd_t line_q[$];
    blit_row_t blit_tab[$];
    int errors = 0;
    int blits_sent = 0;
    bit steady = 1'b0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;

    rect_blit_line_address_generator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic blit_req_t mk_req(int dl, int dt, int dr, int db, int ds,
                                         int sl, int st, int sr, int sb, int ss, int pb);
        blit_req_t r;
        r.dl = shortint'(dl);
        r.dt = shortint'(dt);
        r.dr = shortint'(dr);
        r.db = shortint'(db);
        r.ds = ds[STRIDE_W-1:0];
        r.sl = shortint'(sl);
        r.st = shortint'(st);
        r.sr = shortint'(sr);
        r.sb = shortint'(sb);
        r.ss = ss[STRIDE_W-1:0];
        r.pb = pb[PBITS_W-1:0];
        return r;
    endfunction

    function automatic line_cmd_t mk_cmd(longint da, longint sa, int len, rbl_status_t st);
        line_cmd_t c;
        c.dst_addr = da[ADDR_W-1:0];
        c.src_addr = sa[ADDR_W-1:0];
        c.len = len[LEN_W-1:0];
        c.status = st;
        c.last = 1'b1;
        return c;
    endfunction

    function automatic void add_row(blit_req_t r, bit fixed, line_cmd_t c);
        blit_row_t row;
        row.req = r;
        row.fixed = fixed;
        row.cmd = c;
        blit_tab.push_back(row);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_req(blit_req_t r);
        return {1'b0, r.pb, r.ss, r.sb, r.sr, r.st, r.sl, r.ds, r.db, r.dr, r.dt, r.dl};
    endfunction

    // Intersects the two rectangles and queues one command per overlap row,
    // or a single status result for an empty or too tall overlap.
    function automatic void predict_lines(blit_req_t r);
        int x0, x1, y0, y1, height;
        longint width, bpp, dstep, sstep, da, sa, len;
        line_cmd_t c;
        x0 = (r.dl > r.sl) ? r.dl : r.sl;
        x1 = (r.dr < r.sr) ? r.dr : r.sr;
        y0 = (r.dt > r.st) ? r.dt : r.st;
        y1 = (r.db < r.sb) ? r.db : r.sb;
        if (x0 > x1 || y0 > y1) begin
            line_q.push_back(mk_cmd(0, 0, 0, STATUS_EMPTY));
            return;
        end
        height = y1 - y0 + 1;
        if (height > MAX_LINES) begin
            line_q.push_back(mk_cmd(0, 0, 0, STATUS_TALL));
            return;
        end
        width = longint'(x1 - x0) + 1;
        bpp = (r.pb < 8) ? longint'(r.pb) : longint'({r.pb[6:3], 3'b000});
        len = width * bpp;
        dstep = longint'(r.ds) * 8;
        sstep = longint'(r.ss) * 8;
        da = longint'(y0 - r.dt) * dstep + longint'(x0 - r.dl) * bpp;
        sa = longint'(y0 - r.st) * sstep + longint'(x0 - r.sl) * bpp;
        for (int k = 0; k < height; k++) begin
            c.dst_addr = da[ADDR_W-1:0];
            c.src_addr = sa[ADDR_W-1:0];
            c.len = len[LEN_W-1:0];
            c.status = STATUS_ROW;
            c.last = (k == height - 1);
            line_q.push_back(c);
            da = (da + dstep) & 64'hF_FFFF_FFFF;
            sa = (sa + sstep) & 64'hF_FFFF_FFFF;
        end
    endfunction

    function automatic shortint sat16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return shortint'(v);
    endfunction

    function automatic int spread();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 0;
        if (sel < 9)
            return $urandom_range(1, 15);
        return $urandom_range(0, 65535);
    endfunction

    // One rectangle gets the bound exactly, the other one lies at or beyond it.
    task automatic split_bound(input int bv, input bit is_low, output shortint a,
                               output shortint b);
        int far;
        far = is_low ? bv - spread() : bv + spread();
        if ($urandom_range(0, 1)) begin
            a = sat16(bv);
            b = sat16(far);
        end else begin
            a = sat16(far);
            b = sat16(bv);
        end
    endtask

    function automatic logic [PBITS_W-1:0] pick_pixel_bits();
        case ($urandom_range(0, 11))
            0: return 7'd1;
            1: return 7'd2;
            2: return 7'd4;
            3: return 7'd8;
            4: return 7'd16;
            5: return 7'd24;
            6: return 7'd32;
            7: return 7'd64;
            8: return 7'd0;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic rand_req(output blit_req_t r);
        int x0, y0, w, h, sel;
        if ($urandom_range(0, 99) < 80) begin
            x0 = $urandom_range(0, 65535) - 32768;
            y0 = $urandom_range(0, 65535) - 32768;
            sel = $urandom_range(0, 9);
            w = (sel < 7) ? $urandom_range(1, 32) :
                (sel < 9) ? $urandom_range(1, 2048) : $urandom_range(1, 65536);
            sel = $urandom_range(0, 19);
            h = (sel < 15) ? $urandom_range(1, 8) :
                (sel < 19) ? $urandom_range(9, MAX_LINES) : $urandom_range(MAX_LINES + 1, 400);
            split_bound(x0, 1'b1, r.dl, r.sl);
            split_bound(x0 + w - 1, 1'b0, r.dr, r.sr);
            split_bound(y0, 1'b1, r.dt, r.st);
            split_bound(y0 + h - 1, 1'b0, r.db, r.sb);
            r.ds = 16'($urandom);
            r.ss = 16'($urandom);
            r.pb = pick_pixel_bits();
        end else begin
            r = mk_req($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic send_blit(input blit_req_t r, input bit fixed, input line_cmd_t c);
        while (!steady && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_req(r);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (fixed)
            line_q.push_back(c);
        else
            predict_lines(r);
        blits_sent <= blits_sent + 1;
    endtask

    // Receiver: random back-pressure, one long hold once the traffic is under way.
    initial begin
        forever begin
            @(posedge aclk);
            if (!hold_done && blits_sent >= 100) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    always @(posedge aclk) begin
        line_cmd_t want;
        logic [ADDR_W-1:0] got_dst, got_src;
        logic [LEN_W-1:0] got_len;
        got_dst = m_tdata[ADDR_W-1:0];
        got_src = m_tdata[2*ADDR_W-1:ADDR_W];
        got_len = m_tdata[2*ADDR_W+LEN_W-1:2*ADDR_W];
        if (aresetn && m_tvalid && m_tready) begin
            if (line_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction: dst %h src %h len %0d status %0d last %0d",
                             got_dst, got_src, got_len, m_tuser, m_tlast);
            end else begin
                want = line_q.pop_front();
                if (got_dst !== want.dst_addr || got_src !== want.src_addr ||
                    got_len !== want.len || m_tuser !== want.status ||
                    m_tlast !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: expected dst %h src %h len %0d status %0d last %0d",
                                 want.dst_addr, want.src_addr, want.len, want.status,
                                 want.last);
                        $display("          got dst %h src %h len %0d status %0d last %0d",
                                 got_dst, got_src, got_len, m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("** rect_blit_line_address_generator_core: FAILED **");
            $finish;
        end
    end

    initial begin
        blit_req_t r;
        line_cmd_t none;
        none = mk_cmd(0, 0, 0, STATUS_ROW);

        // Rows with a result that can be read off directly.
        add_row(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8), 1'b1, mk_cmd(0, 0, 8, STATUS_ROW));
        add_row(mk_req(0, 0, 9, 9, 16, 10, 0, 19, 9, 16, 8), 1'b1,
                mk_cmd(0, 0, 0, STATUS_EMPTY));
        add_row(mk_req(0, 0, 9, 9, 16, 0, 10, 9, 19, 16, 8), 1'b1,
                mk_cmd(0, 0, 0, STATUS_EMPTY));
        add_row(mk_req(5, 0, 4, 9, 16, 0, 0, 9, 9, 16, 8), 1'b1,
                mk_cmd(0, 0, 0, STATUS_EMPTY));
        add_row(mk_req(0, 0, 9, 64, 16, 0, 0, 9, 64, 16, 8), 1'b1,
                mk_cmd(0, 0, 0, STATUS_TALL));
        add_row(mk_req(-32768, -32768, 32767, 32767, 65535,
                       -32768, -32768, 32767, 32767, 65535, 127), 1'b1,
                mk_cmd(0, 0, 0, STATUS_TALL));
        // Rows checked against the predictor.
        add_row(mk_req(-32768, -32768, 32767, -32705, 65535,
                       -32768, -32768, 32767, -32705, 65535, 64), 1'b0, none);
        add_row(mk_req(-32768, 0, 32767, 0, 1, -32768, 0, 32767, 0, 1, 127), 1'b0, none);
        add_row(mk_req(-32768, -32768, 32767, 32767, 65535,
                       32000, 32764, 32767, 32767, 1, 64), 1'b0, none);
        add_row(mk_req(0, 0, 19, 3, 100, 5, 1, 30, 9, 200, 0), 1'b0, none);
        add_row(mk_req(0, 0, 19, 3, 100, 5, 1, 30, 9, 200, 1), 1'b0, none);
        add_row(mk_req(0, 0, 19, 3, 100, 5, 1, 30, 9, 200, 2), 1'b0, none);
        add_row(mk_req(0, 0, 19, 3, 100, 5, 1, 30, 9, 200, 4), 1'b0, none);
        add_row(mk_req(0, 0, 19, 3, 100, 5, 1, 30, 9, 200, 7), 1'b0, none);
        add_row(mk_req(0, 0, 19, 3, 100, 5, 1, 30, 9, 200, 9), 1'b0, none);
        add_row(mk_req(0, 0, 19, 3, 100, 5, 1, 30, 9, 200, 3), 1'b0, none);
        add_row(mk_req(-10, -10, 10, 10, 0, -3, -4, 3, 4, 0, 32), 1'b0, none);
        add_row(mk_req(-100, -50, -20, -1, 640, -60, -30, 40, 20, 320, 24), 1'b0, none);
        add_row(mk_req(7, -32768, 7, 32767, 4096, 0, 100, 100, 163, 8192, 16), 1'b0, none);
        add_row(mk_req(32767, 32767, 32767, 32767, 65535,
                       -32768, -32768, 32767, 32767, 65535, 64), 1'b0, none);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (blit_tab[i])
            send_blit(blit_tab[i].req, blit_tab[i].fixed, blit_tab[i].cmd);

        for (int i = 0; i < RANDOM_BLITS; i++) begin
            if (i == 30) begin
                s_tvalid <= 1'b0;
                while (line_q.size() != 0)
                    @(posedge aclk);
            end
            steady <= (i >= 150 && i < 210);
            rand_req(r);
            send_blit(r, 1'b0, none);
        end
        s_tvalid <= 1'b0;
        steady <= 1'b0;

        while (line_q.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);

        if (errors == 0)
            $display("** rect_blit_line_address_generator_core: PASSED **");
        else
            $display("** rect_blit_line_address_generator_core: FAILED **");
        $finish;
    end

endmodule

// ===== rect_blit_line_address_generator_core.f =====
rtl/rbl_pkg.sv
rtl/rbl_datapath.sv
rtl/rbl_ctrl.sv
rtl/rect_blit_line_address_generator_core.sv
tb/tb.sv
